// ----- hw/rtl/tscm_pkg.sv -----
// shared constants for the transport stream continuity monitor
package tscm_pkg;

   // packet header constants
   localparam int unsigned PID_BITS   = 13;
   localparam int unsigned PID_COUNT  = 1 << PID_BITS;
   localparam int unsigned CC_BITS    = 4;
   localparam int unsigned OUT_BITS   = 32;

   localparam logic [7:0]          SYNC_VALUE = 8'h47;
   localparam logic [PID_BITS-1:0] NULL_PID   = 13'h1FFF;

   // adaptation field control codes
   typedef enum logic [1:0] {
      ADAPT_RESERVED     = 2'd0,
      ADAPT_PAYLOAD_ONLY = 2'd1,
      ADAPT_FIELD_ONLY   = 2'd2,
      ADAPT_BOTH         = 2'd3
   } adapt_type;

endpackage

// ----- hw/rtl/ts_continuity_monitor.sv -----
// transport stream continuity monitor: per-PID table with read-modify-write pipeline
// an accepted item passes the stage-one registers, then the result register, which
//   loads only while the result port is not stalled
// throughput: one item per cycle unless stalled by the clearing sweep or result port;
//   the per-PID table has one read and one write port; a same-PID item is forwarded
// reset: a clearing pass sweeps all 8192 table entries, one per cycle; no item is
//   accepted during the sweep, and the drop and scramble sums reset to zero
module ts_continuity_monitor #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_sync_word,
   input  logic                           req_error_bit,
   input  logic [tscm_pkg::PID_BITS-1:0]  req_pid,
   input  logic [1:0]                     req_scramble_ctl,
   input  logic [1:0]                     req_adapt_ctl,
   input  logic [tscm_pkg::CC_BITS-1:0]   req_cont_counter,
   input  logic [7:0]                     req_adapt_length,
   input  logic                           req_discontinuity,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_accepted,
   output logic                           rsp_drop_now,
   output logic                           rsp_scramble_now,
   output logic [tscm_pkg::OUT_BITS-1:0]  rsp_pid_total_count,
   output logic [tscm_pkg::OUT_BITS-1:0]  rsp_pid_drop_count,
   output logic [tscm_pkg::OUT_BITS-1:0]  rsp_pid_scramble_count,
   output logic [tscm_pkg::OUT_BITS-1:0]  rsp_all_drop_count,
   output logic [tscm_pkg::OUT_BITS-1:0]  rsp_all_scramble_count
);

   localparam int unsigned PB = tscm_pkg::PID_BITS;
   localparam int unsigned CB = tscm_pkg::CC_BITS;

   typedef struct packed {
      logic                  seen;
      logic [CB-1:0]         prev;
      logic                  dup;
      logic [COUNT_BITS-1:0] total;
      logic [COUNT_BITS-1:0] drops;
      logic [COUNT_BITS-1:0] scrambles;
   } entry_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // per-PID table
   entry_type mem [tscm_pkg::PID_COUNT];

   logic                  clr_active_ff, clr_active_in;
   logic [PB-1:0]         clr_addr_ff, clr_addr_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_ok_ff;
   logic [PB-1:0]         s1_pid_ff;
   logic [1:0]            s1_sc_ff;
   logic [1:0]            s1_ac_ff;
   logic [CB-1:0]         s1_cc_ff;
   logic [7:0]            s1_alen_ff;
   logic                  s1_disc_ff;
   entry_type             rdata_ff;
   logic                  fwd_hit_ff;
   entry_type             fwd_data_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [COUNT_BITS-1:0] drop_sum_ff, drop_sum_in;
   logic [COUNT_BITS-1:0] scr_sum_ff, scr_sum_in;

   logic                          res_accepted_ff;
   logic                          res_drop_now_ff;
   logic                          res_scramble_now_ff;
   logic [tscm_pkg::OUT_BITS-1:0] res_pid_total_ff;
   logic [tscm_pkg::OUT_BITS-1:0] res_pid_drops_ff;
   logic [tscm_pkg::OUT_BITS-1:0] res_pid_scrambles_ff;
   logic [tscm_pkg::OUT_BITS-1:0] res_all_drops_ff;
   logic [tscm_pkg::OUT_BITS-1:0] res_all_scrambles_ff;

   logic                  accept;
   logic                  s1_move;
   logic                  s1_write;
   logic                  wr_en;
   logic [PB-1:0]         wr_addr;
   entry_type             wr_data;
   entry_type             cur;
   entry_type             upd;
   logic                  dropped;
   logic                  scrambled;
   logic                  unexcused;

   // handshake
   assign s1_move   = !out_valid_ff || !rsp_stall;
   assign req_stall = clr_active_ff || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;
   assign s1_write  = s1_valid_ff && s1_move && s1_ok_ff;
   assign rsp_valid = out_valid_ff;

   // result outputs
   assign rsp_accepted           = res_accepted_ff;
   assign rsp_drop_now           = res_drop_now_ff;
   assign rsp_scramble_now       = res_scramble_now_ff;
   assign rsp_pid_total_count    = res_pid_total_ff;
   assign rsp_pid_drop_count     = res_pid_drops_ff;
   assign rsp_pid_scramble_count = res_pid_scrambles_ff;
   assign rsp_all_drop_count     = res_all_drops_ff;
   assign rsp_all_scramble_count = res_all_scrambles_ff;

   // entry update for the item in stage one
   always_comb begin
      cur       = fwd_hit_ff ? fwd_data_ff : rdata_ff;
      upd       = cur;
      dropped   = 1'b0;
      scrambled = 1'b0;
      unexcused = (s1_ac_ff == tscm_pkg::ADAPT_PAYLOAD_ONLY) || (s1_alen_ff == 8'd0)
                  || !s1_disc_ff;
      if (!cur.seen) begin
         upd.seen      = 1'b1;
         upd.prev      = s1_cc_ff - {{(CB-1){1'b0}}, 1'b1};
         upd.dup       = 1'b0;
         upd.total     = '0;
         upd.drops     = '0;
         upd.scrambles = '0;
      end
      upd.total = (upd.total == COUNT_MAX) ? upd.total : upd.total + 1'b1;
      if (s1_pid_ff != tscm_pkg::NULL_PID) begin
         scrambled = (s1_sc_ff != 2'd0);
         if (s1_ac_ff == tscm_pkg::ADAPT_RESERVED || s1_ac_ff == tscm_pkg::ADAPT_FIELD_ONLY)
         begin
            upd.dup = 1'b0;
         end else if (upd.prev == s1_cc_ff) begin
            if (unexcused) begin
               if (!upd.dup) begin
                  upd.dup = 1'b1;
               end else begin
                  dropped = 1'b1;
               end
            end else begin
               upd.dup = 1'b0;
            end
         end else begin
            if ((upd.prev + {{(CB-1){1'b0}}, 1'b1}) != s1_cc_ff && unexcused) begin
               dropped = 1'b1;
            end
            upd.dup = 1'b0;
         end
         upd.prev = s1_cc_ff;
         if (scrambled) begin
            upd.scrambles = (upd.scrambles == COUNT_MAX) ? upd.scrambles
                                                         : upd.scrambles + 1'b1;
         end
         if (dropped) begin
            upd.drops = (upd.drops == COUNT_MAX) ? upd.drops : upd.drops + 1'b1;
         end
      end
   end

   // table write port: clearing sweep or write-back
   always_comb begin
      wr_en   = clr_active_ff || s1_write;
      wr_addr = clr_active_ff ? clr_addr_ff : s1_pid_ff;
      wr_data = clr_active_ff ? entry_type'('0) : upd;
   end

   // next state of control registers
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {PB{1'b1}}) begin
            clr_active_in = 1'b0;
         end
      end
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = (s1_valid_ff && s1_move) ? 1'b1
                     : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);
      drop_sum_in  = drop_sum_ff;
      scr_sum_in   = scr_sum_ff;
      if (s1_write && dropped && drop_sum_ff != COUNT_MAX) begin
         drop_sum_in = drop_sum_ff + 1'b1;
      end
      if (s1_write && scrambled && scr_sum_ff != COUNT_MAX) begin
         scr_sum_in = scr_sum_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         drop_sum_ff   <= '0;
         scr_sum_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         drop_sum_ff   <= drop_sum_in;
         scr_sum_ff    <= scr_sum_in;
      end
   end

   // table access
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rdata_ff <= mem[req_pid];
      end
   end

   // stage one item and forwarding of a same-cycle write-back
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ok_ff    <= (req_sync_word == tscm_pkg::SYNC_VALUE) && !req_error_bit;
         s1_pid_ff   <= req_pid;
         s1_sc_ff    <= req_scramble_ctl;
         s1_ac_ff    <= req_adapt_ctl;
         s1_cc_ff    <= req_cont_counter;
         s1_alen_ff  <= req_adapt_length;
         s1_disc_ff  <= req_discontinuity;
         fwd_hit_ff  <= s1_write && (s1_pid_ff == req_pid);
         fwd_data_ff <= upd;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_move) begin
         res_accepted_ff      <= s1_ok_ff;
         res_drop_now_ff      <= s1_ok_ff && dropped;
         res_scramble_now_ff  <= s1_ok_ff && scrambled;
         res_pid_total_ff     <= s1_ok_ff ? tscm_pkg::OUT_BITS'(upd.total) : '0;
         res_pid_drops_ff     <= s1_ok_ff ? tscm_pkg::OUT_BITS'(upd.drops) : '0;
         res_pid_scrambles_ff <= s1_ok_ff ? tscm_pkg::OUT_BITS'(upd.scrambles) : '0;
         res_all_drops_ff     <= tscm_pkg::OUT_BITS'(drop_sum_in);
         res_all_scrambles_ff <= tscm_pkg::OUT_BITS'(scr_sum_in);
      end
   end

endmodule
